// ----- rtl/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge, masked while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent, masked while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/taat_pkg.sv -----
`timescale 1ns / 1ps
package taat_pkg;

    // request kinds
    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_DEL = 1'b1;

    // result codes
    typedef logic [2:0] t_status;
    localparam t_status ST_ADDED     = 3'd0;
    localparam t_status ST_DUPLICATE = 3'd1;
    localparam t_status ST_FULL      = 3'd2;
    localparam t_status ST_DELETED   = 3'd3;
    localparam t_status ST_NOT_FOUND = 3'd4;

    // reset value of the hold time
    localparam logic [31:0] HOLD_RESET = 32'd30000;

    // one stored table entry
    typedef struct packed {
        logic [31:0] expiry;
        logic [31:0] address;
    } t_entry;

endpackage

// ----- rtl/taat_ram.sv -----
`timescale 1ns / 1ps
module taat_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/timed_address_admission_table_core.sv -----
`timescale 1ns / 1ps
// Admission table for IPv4 addresses with per-entry aging.
// Input channel s_axis: tuser carries the request kind (0 add, 1 delete),
// tdata carries the address in bits 31:0 and the current tick in bits 63:32.
// Output channel m_axis: one 8-bit word per request, status in bits 2:0
// (added, duplicate, full, deleted, not found).
// i_cfg_we / i_cfg_wdata load the hold time; write it only while idle.
// Each request walks the table one entry per cycle through a memory with a
// registered read, and the result goes to the output register once the walk
// ends; an add that meets a live duplicate ends the walk early. The walk over
// the entry memory sets the rate; requests are processed one at a time, and a
// new request is taken only once the previous result is in the output register.
// Reset clears every valid bit at once and loads a hold time of 30000; the
// address and expiry memory needs no clearing pass.
// The result sits in an output register, so a new request is taken while the
// previous result waits; if the receiver still stalls when the next result is
// ready, the block holds that result and takes no further request.
module timed_address_admission_table_core #(
    parameter int ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: hold time
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    // request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // ip_address[31:0], current_time[63:32]
    input  logic        s_axis_tuser,   // cmd[0]
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // status[2:0], zero fill[7:3]
);
    import taat_pkg::*;

    `include "assert_macros.svh"

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    // control state
    logic [1:0]         r_state, n_state;
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [IDX_W-1:0]   r_rd_idx, n_rd_idx;
    logic               r_out_valid, n_out_valid;
    logic [31:0]        r_hold, n_hold;

    // request payload and scan bookkeeping
    logic               r_cmd, n_cmd;
    logic [31:0]        r_key, n_key;
    logic [31:0]        r_now, n_now;
    logic [31:0]        r_new_exp, n_new_exp;
    logic [IDX_W-1:0]   r_chk_idx, n_chk_idx;
    logic               r_slot_found, n_slot_found;
    logic [IDX_W-1:0]   r_slot, n_slot;
    logic               r_hit, n_hit;
    t_status            r_res, n_res;
    t_status            r_status, n_status;

    // memory port
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    t_entry             ram_wdata;
    t_entry             ram_rdata;

    // per-entry decode
    logic               accept;
    logic               chk_valid;
    logic               addr_hit;
    logic               expired;
    logic               is_free;
    logic               last;
    logic               slot_found_nx;
    logic [IDX_W-1:0]   slot_nx;

    taat_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_status};

    // look at the entry whose data just came out of the memory
    assign chk_valid     = r_valid[r_chk_idx];
    assign addr_hit      = (ram_rdata.address == r_key);
    assign expired       = chk_valid && (r_now > ram_rdata.expiry);
    assign is_free       = !chk_valid || expired;
    assign last          = (r_chk_idx == IDX_W'(ENTRIES - 1));
    assign slot_found_nx = r_slot_found || is_free;
    assign slot_nx       = r_slot_found ? r_slot : r_chk_idx;

    // next-state logic
    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_rd_idx     = r_rd_idx;
        n_out_valid  = r_out_valid;
        n_hold       = r_hold;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_now        = r_now;
        n_new_exp    = r_new_exp;
        n_chk_idx    = r_chk_idx;
        n_slot_found = r_slot_found;
        n_slot       = r_slot;
        n_hit        = r_hit;
        n_res        = r_res;
        n_status     = r_status;
        ram_we       = 1'b0;
        ram_waddr    = slot_nx;
        ram_wdata    = '{expiry: r_new_exp, address: r_key};

        if (i_cfg_we) begin
            n_hold = i_cfg_wdata;
        end

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                // memory is reading entry 0 during this cycle
                if (accept) begin
                    n_cmd        = s_axis_tuser;
                    n_key        = s_axis_tdata[31:0];
                    n_now        = s_axis_tdata[63:32];
                    n_new_exp    = s_axis_tdata[63:32] + r_hold;
                    n_chk_idx    = '0;
                    n_rd_idx     = IDX_W'(1);
                    n_slot_found = 1'b0;
                    n_hit        = 1'b0;
                    n_state      = S_SCAN;
                end
            end
            S_SCAN: begin
                n_chk_idx = r_chk_idx + IDX_W'(1);
                n_rd_idx  = r_rd_idx + IDX_W'(1);
                if (r_cmd == CMD_ADD) begin
                    // age the entry, stop on a live duplicate
                    if (expired) begin
                        n_valid[r_chk_idx] = 1'b0;
                    end
                    n_slot_found = slot_found_nx;
                    n_slot       = slot_nx;
                    if (chk_valid && !expired && addr_hit) begin
                        n_res    = ST_DUPLICATE;
                        n_rd_idx = '0;
                        n_state  = S_FIN;
                    end else if (last) begin
                        if (slot_found_nx) begin
                            ram_we           = 1'b1;
                            n_valid[slot_nx] = 1'b1;
                            n_res            = ST_ADDED;
                        end else begin
                            n_res = ST_FULL;
                        end
                        n_rd_idx = '0;
                        n_state  = S_FIN;
                    end
                end else begin
                    // delete every valid match
                    if (chk_valid && addr_hit) begin
                        n_valid[r_chk_idx] = 1'b0;
                        n_hit              = 1'b1;
                    end
                    if (last) begin
                        n_res    = (r_hit || (chk_valid && addr_hit)) ? ST_DELETED
                                                                      : ST_NOT_FOUND;
                        n_rd_idx = '0;
                        n_state  = S_FIN;
                    end
                end
            end
            S_FIN: begin
                // hand the result over once the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_status    = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
            r_hold      <= HOLD_RESET;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
            r_hold      <= n_hold;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_now        <= n_now;
        r_new_exp    <= n_new_exp;
        r_chk_idx    <= n_chk_idx;
        r_slot_found <= n_slot_found;
        r_slot       <= n_slot;
        r_hit        <= n_hit;
        r_res        <= n_res;
        r_status     <= n_status;
    end

    // checks
    `ASSERT_NEXT(a_accept_scans, i_clk, i_rst_n, accept,
        r_state == S_SCAN && r_chk_idx == '0,
        "accepted request did not start a scan at entry 0")
    `ASSERT_CLK(a_scan_in_range, i_clk, i_rst_n,
        (r_state != S_SCAN) || (r_chk_idx <= IDX_W'(ENTRIES - 1)),
        "scan index beyond table")
    `ASSERT_NEXT(a_fin_loads_out, i_clk, i_rst_n,
        r_state == S_FIN && (!r_out_valid || m_axis_tready),
        r_out_valid && r_status == $past(r_res),
        "finished result not loaded into output register")

endmodule

// ----- tb/tb_timed_address_admission_table_core.sv -----
`timescale 1ns / 1ps
module tb_timed_address_admission_table_core;
    import taat_pkg::*;

    localparam int TBL_DEPTH = 64;
    // walk over the table plus the read and output registers
    localparam int SETTLE_CYCLES = TBL_DEPTH + 8;

    typedef struct packed {
        logic        cmd;
        logic [31:0] addr;
        logic [31:0] now;
    } t_admit_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;     // ip_address[31:0], current_time[63:32]
    logic        s_axis_tuser = 1'b0;   // cmd[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // status[2:0], zero fill[7:3]

    // shadow of the admission table
    logic        tbl_valid [0:TBL_DEPTH-1];
    logic [31:0] tbl_addr [0:TBL_DEPTH-1];
    logic [31:0] tbl_expiry [0:TBL_DEPTH-1];
    logic [31:0] hold_ticks = HOLD_RESET;

    t_admit_req req_pending_q [$];
    t_status    status_expect_q [$];
    t_admit_req cur_req;
    bit         req_taken = 1'b0;
    bit         calm = 1'b0;
    int         src_gap = 0;
    int         snk_stall = 0;
    int         accept_count = 0;
    int         err_count = 0;

    timed_address_admission_table_core #(
        .ENTRIES(TBL_DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        err_count++;
    endtask

    // expected status of one request, updating the shadow table
    function automatic t_status admit_predict(input t_admit_req rq);
        int      slot;
        int      k;
        bit      dup;
        t_status st;
        slot = -1;
        dup = 1'b0;
        if (rq.cmd == CMD_ADD) begin
            // scan stops at a live duplicate, expired entries below it stay freed
            for (k = 0; k < TBL_DEPTH && !dup; k++) begin
                if (tbl_valid[k]) begin
                    if (rq.now > tbl_expiry[k]) begin
                        tbl_valid[k] = 1'b0;
                        if (slot < 0) slot = k;
                    end else if (tbl_addr[k] == rq.addr) begin
                        dup = 1'b1;
                    end
                end else if (slot < 0) begin
                    slot = k;
                end
            end
            if (dup) begin
                st = ST_DUPLICATE;
            end else if (slot < 0) begin
                st = ST_FULL;
            end else begin
                tbl_valid[slot] = 1'b1;
                tbl_addr[slot] = rq.addr;
                tbl_expiry[slot] = rq.now + hold_ticks;
                st = ST_ADDED;
            end
        end else begin
            // delete ignores ageing
            st = ST_NOT_FOUND;
            for (k = 0; k < TBL_DEPTH; k++) begin
                if (tbl_valid[k] && tbl_addr[k] == rq.addr) begin
                    tbl_valid[k] = 1'b0;
                    st = ST_DELETED;
                end
            end
        end
        return st;
    endfunction

    // gap after a request on the sender side
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 150);
    endfunction

    // stall length on the receiver side
    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 75) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || req_taken) begin
            req_taken = 1'b0;
            if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (req_pending_q.size() > 0) begin
                cur_req = req_pending_q.pop_front();
                s_axis_tdata <= {cur_req.now, cur_req.addr};
                s_axis_tuser <= cur_req.cmd;
                s_axis_tvalid <= 1'b1;
                src_gap = pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // request accepted: predict, and now and then switch idling off or back on
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            status_expect_q.push_back(admit_predict(cur_req));
            req_taken = 1'b1;
            accept_count++;
            if (accept_count % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        end
    end

    // result receiver stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (snk_stall > 0) begin
            snk_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            snk_stall = pick_stall();
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_status want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (status_expect_q.size() == 0) begin
                report_mismatch($sformatf("result %0h with none expected", m_axis_tdata));
            end else begin
                want = status_expect_q.pop_front();
                if (m_axis_tdata[2:0] !== want)
                    report_mismatch($sformatf("status %0d, expected %0d",
                        m_axis_tdata[2:0], want));
                if (m_axis_tdata[7:3] !== 5'd0)
                    report_mismatch($sformatf("fill bits %0h not zero", m_axis_tdata[7:3]));
            end
        end
    end

    task automatic push_req(input logic cmd, input logic [31:0] addr, input logic [31:0] now);
        t_admit_req rq;
        rq.cmd = cmd;
        rq.addr = addr;
        rq.now = now;
        req_pending_q.push_back(rq);
    endtask

    // wait until every request is answered and the walk has settled
    task automatic wait_idle();
        while (req_pending_q.size() != 0 || s_axis_tvalid || status_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_hold(input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        hold_ticks = value;
    endtask

    // one hold-time setting with random traffic over an address pool
    task automatic run_phase(input logic [31:0] hold, input int n_items,
                             input logic [31:0] tick0, input int max_step, input int pool_n);
        logic [31:0] pool [0:127];
        logic [31:0] tick;
        logic [31:0] addr;
        logic        cmd;
        int          i;
        int          r;
        wait_idle();
        set_hold(hold);
        for (i = 0; i < pool_n; i++) pool[i] = $urandom;
        tick = tick0;
        for (i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            if (r < 5) tick = $urandom;
            else if (r < 8) tick = tick - $urandom_range(0, max_step);
            else tick = tick + $urandom_range(0, max_step);
            cmd = ($urandom_range(0, 99) < 78) ? CMD_ADD : CMD_DEL;
            addr = ($urandom_range(0, 99) < 88) ? pool[$urandom_range(0, pool_n - 1)]
                                                : $urandom;
            push_req(cmd, addr, tick);
        end
    endtask

    // stimulus
    initial begin
        for (int k = 0; k < TBL_DEPTH; k++) begin
            tbl_valid[k] = 1'b0;
            tbl_addr[k] = '0;
            tbl_expiry[k] = '0;
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset hold time
        push_req(CMD_ADD, 32'h0000_0000, 32'd0);
        // expiry equal to now is still live
        push_req(CMD_ADD, 32'h0000_0000, 32'd30000);
        push_req(CMD_ADD, 32'h0000_0000, 32'd30001);
        push_req(CMD_ADD, 32'hFFFF_FFFF, 32'd60001);
        push_req(CMD_DEL, 32'h1234_5678, 32'd0);
        push_req(CMD_DEL, 32'hFFFF_FFFF, 32'd0);
        // expiry wraps, then the fresh entry ages out on the next add
        push_req(CMD_ADD, 32'hC0A8_0001, 32'hFFFF_FFFF);
        push_req(CMD_ADD, 32'h0A00_0001, 32'hFFFF_FFF0);
        push_req(CMD_DEL, 32'h0A00_0001, 32'd0);
        // duplicate stops the scan with expired entries on both sides
        push_req(CMD_ADD, 32'h1111_1111, 32'd100);
        push_req(CMD_ADD, 32'h2222_2222, 32'd5000);
        push_req(CMD_ADD, 32'h3333_3333, 32'd200);
        push_req(CMD_ADD, 32'h2222_2222, 32'd31000);
        push_req(CMD_ADD, 32'h4444_4444, 32'd31000);
        push_req(CMD_ADD, 32'h3333_3333, 32'd31000);
        // delete clears an expired entry too
        push_req(CMD_DEL, 32'h4444_4444, 32'hFFFF_FFFF);
        push_req(CMD_DEL, 32'h0000_0000, 32'hFFFF_FFFF);
        push_req(CMD_ADD, 32'hAAAA_AAAA, 32'h5555_5555);
        push_req(CMD_ADD, 32'h5555_5555, 32'hAAAA_AAAA);

        // random traffic under several hold times
        run_phase(32'd0,         180, $urandom, 2,  24);
        run_phase(32'hFFFF_FFFF, 180, 32'd0,    0,  72);
        run_phase(32'd20,        180, $urandom, 8,  40);
        run_phase(32'd300,       180, $urandom, 8,  72);
        run_phase($urandom,      180, $urandom, 32'h7FFF_FFFF, 72);
        run_phase(32'hFFFF_FF00, 180, 32'hFFFF_FF80, 64, 30);
        run_phase(32'd5,         180, $urandom, 3,  20);
        run_phase(32'd30000,     180, $urandom, 40, 72);

        wait_idle();
        if (err_count == 0) begin
            $display("tb_timed_address_admission_table_core: done, clean");
        end else begin
            $display("tb_timed_address_admission_table_core: done, errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #6000000;
        $display("tb_timed_address_admission_table_core: done, errors");
        $finish;
    end

endmodule

// ----- timed_address_admission_table_core.f -----
+incdir+rtl
rtl/taat_pkg.sv
rtl/taat_ram.sv
rtl/timed_address_admission_table_core.sv
tb/tb_timed_address_admission_table_core.sv
